// ----- rtl/core/bost_pkg.sv -----
// Shared constants, types and helpers for the BUFR operator state tracker.
package bost_pkg;

   // Default depth of the associated-field stack
   localparam int ASSOC_DEPTH_DEF = 16;

   // Field widths
   localparam int OP_CLASS_W   = 6;
   localparam int OP_ARG_W     = 8;
   localparam int STATUS_W     = 3;
   localparam int WIDTH_CHG_W  = 11;
   localparam int SCALE_CHG_W  = 9;
   localparam int FLOAT_W_W    = 7;
   localparam int FLAGS_W      = 6;
   localparam int ASSOC_TOT_W  = 12;
   localparam int STRING_W_W   = 11;
   localparam int EDITION_W    = 4;
   localparam int ENFORCE_W    = 2;
   localparam int CSR_DATA_W   = 4;

   // Register indexes on the csr port
   localparam logic CSR_EDITION = 1'b0;
   localparam logic CSR_ENFORCE = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNSUPP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ED_WARN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ED_REJECT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLOAT_BAD = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

   // Enforcement levels
   localparam logic [ENFORCE_W-1:0] ENF_LAX    = 2'd0;
   localparam logic [ENFORCE_W-1:0] ENF_WARN   = 2'd1;
   localparam logic [ENFORCE_W-1:0] ENF_STRICT = 2'd2;

   // Operator classes (X of 2XXYYY)
   localparam logic [OP_CLASS_W-1:0] OPC_WIDTH   = 6'd1;
   localparam logic [OP_CLASS_W-1:0] OPC_SCALE   = 6'd2;
   localparam logic [OP_CLASS_W-1:0] OPC_REFVAL  = 6'd3;
   localparam logic [OP_CLASS_W-1:0] OPC_ASSOC   = 6'd4;
   localparam logic [OP_CLASS_W-1:0] OPC_STRING  = 6'd5;
   localparam logic [OP_CLASS_W-1:0] OPC_LOCAL   = 6'd6;
   localparam logic [OP_CLASS_W-1:0] OPC_INCR    = 6'd7;
   localparam logic [OP_CLASS_W-1:0] OPC_TEXT    = 6'd8;
   localparam logic [OP_CLASS_W-1:0] OPC_FLOAT   = 6'd9;
   localparam logic [OP_CLASS_W-1:0] OPC_QUAL    = 6'd22;
   localparam logic [OP_CLASS_W-1:0] OPC_SUBST   = 6'd23;
   localparam logic [OP_CLASS_W-1:0] OPC_STATS   = 6'd24;
   localparam logic [OP_CLASS_W-1:0] OPC_BMAP    = 6'd36;
   localparam logic [OP_CLASS_W-1:0] OPC_REUSE   = 6'd37;
   localparam logic [OP_CLASS_W-1:0] OPC_EVENT   = 6'd41;

   // Editions that introduced the newer operators
   localparam logic [EDITION_W-1:0] ED_3 = 4'd3;
   localparam logic [EDITION_W-1:0] ED_4 = 4'd4;
   localparam logic [EDITION_W-1:0] ED_5 = 4'd5;

   // Mode flag bit positions
   localparam int FL_SUBST = 0;
   localparam int FL_STATS = 1;
   localparam int FL_BMAP  = 2;
   localparam int FL_REUSE = 3;
   localparam int FL_QUAL  = 4;
   localparam int FL_EVENT = 5;

   // Operand values with a special meaning
   localparam logic [OP_ARG_W-1:0] ARG_BIAS  = 8'd128;
   localparam logic [OP_ARG_W-1:0] ARG_MAX   = 8'd255;
   localparam logic [OP_ARG_W-1:0] ARG_FL32  = 8'd32;
   localparam logic [OP_ARG_W-1:0] ARG_FL64  = 8'd64;

   // Reciprocal of 3 scaled by 2^13, exact for dividends up to 2552
   localparam logic [11:0] RECIP3     = 12'd2731;
   localparam int          RECIP3_SHR = 13;

   // Stack command from the decoder
   typedef struct packed {
      logic                push;
      logic                pop;
      logic [OP_ARG_W-1:0] data;
   } stk_cmd_type;

   // Status for an operator that first appeared in edition opver
   function automatic logic [STATUS_W-1:0] edition_check(
      input logic [EDITION_W-1:0] edition,
      input logic [ENFORCE_W-1:0] enforce,
      input logic [EDITION_W-1:0] opver,
      input logic [STATUS_W-1:0]  st
   );
      logic [STATUS_W-1:0] res;
      if (edition >= opver || enforce == ENF_LAX) begin
         res = st;
      end else if (enforce == ENF_STRICT) begin
         res = ST_ED_REJECT;
      end else begin
         res = ST_ED_WARN;
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/bost_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module bost_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bost_stack.sv -----
// Associated-field width stack: top entry in a register, the rest in RAM, plus running sum.
module bost_stack #(
   parameter int DEPTH = bost_pkg::ASSOC_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bost_pkg::stk_cmd_type                 cmd,
   output logic                                  full,
   output logic [$clog2(DEPTH*255+1)-1:0]        sum_nxt
);

   localparam int DW   = $clog2(DEPTH + 1);
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SumW = $clog2(DEPTH * 255 + 1);
   localparam int AigW = bost_pkg::OP_ARG_W;

   logic [DW-1:0]   depth_ff, depth_in;
   logic [AigW-1:0] top_ff, top_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic            byp_ff, byp_in;
   logic [AigW-1:0] byp_data_ff;
   logic [AigW-1:0] rd_data, below;
   logic            do_push, do_pop, wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;

   assign full    = (depth_ff == DW'(DEPTH));
   assign do_push = cmd.push && !full;
   assign do_pop  = cmd.pop && (depth_ff != '0);

   // entry just spilled to RAM is not yet on the RAM read port, so it comes from the bypass copy
   assign below   = byp_ff ? byp_data_ff : rd_data;

   // old top goes down to RAM on a push over a non-empty stack
   assign wr_en   = do_push && (depth_ff != '0);
   assign wr_addr = AW'(depth_ff - DW'(1));
   assign byp_in  = wr_en;

   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      sum_in   = sum_ff;
      if (do_push) begin
         depth_in = depth_ff + DW'(1);
         top_in   = cmd.data;
         sum_in   = sum_ff + SumW'(cmd.data);
      end else if (do_pop) begin
         depth_in = depth_ff - DW'(1);
         top_in   = below;
         sum_in   = sum_ff - SumW'(top_ff);
      end
   end

   // keep the entry under the new top on the read port
   assign rd_addr = AW'(depth_in - DW'(2));
   assign sum_nxt = sum_in;

   bost_ram #(
      .WIDTH (AigW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         sum_ff   <= '0;
         byp_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         sum_ff   <= sum_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= top_ff;
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(DEPTH))
      else $error("stack depth beyond capacity");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      depth_ff == '0 |-> sum_ff == '0)
      else $error("empty stack with non-zero sum");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.push && !full |=> depth_ff == $past(depth_ff) + DW'(1))
      else $error("accepted push did not grow the stack");

endmodule

// ----- rtl/core/bufr_operator_state_tracker_core.sv -----
// Top level of the BUFR table C operator state tracker.
//
//  Channel | Dir | Payload                                   | Handshake
//  req_    | in  | tdata[16]: op_class, op_arg               | tvalid / tready
//  rsp_    | out | tdata[96]: status .. clear_overrides       | tvalid / tready
//  csr_    | in  | index[1], data[4]: edition, enforce_level | valid / ready
//
// One item per cycle sustained while the result is not stalled; an item passes the input
// register, then the result register, and its result is offered from the result register.
// The modifier registers and the stack top update as each item moves to the result register.
// Reset clears all modifiers and the stack depth; no clearing pass is needed.
// A stalled result holds; the input register still takes one more item.
module bufr_operator_state_tracker_core #(
   parameter int ASSOC_DEPTH = bost_pkg::ASSOC_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // op_class[5:0], op_arg[13:6], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,    // status[2:0], width_change[13:3],
                                     // scale_change[22:14], ref_value_op[30:23],
                                     // ref_value_increase[38:31], local_width[46:39],
                                     // float_width[53:47], text_redefine[61:54],
                                     // mode_flags[67:62], assoc_total_bits[79:68],
                                     // string_width[90:80], clear_overrides[91]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);

   localparam int SumW = $clog2(ASSOC_DEPTH * 255 + 1);
   localparam int ClsW = bost_pkg::OP_CLASS_W;
   localparam int ArgW = bost_pkg::OP_ARG_W;
   localparam int StW  = bost_pkg::STATUS_W;
   localparam int WcW  = bost_pkg::WIDTH_CHG_W;
   localparam int ScW  = bost_pkg::SCALE_CHG_W;
   localparam int FwW  = bost_pkg::FLOAT_W_W;
   localparam int FlW  = bost_pkg::FLAGS_W;
   localparam int AtW  = bost_pkg::ASSOC_TOT_W;
   localparam int SwW  = bost_pkg::STRING_W_W;
   localparam int EdW  = bost_pkg::EDITION_W;
   localparam int EnW  = bost_pkg::ENFORCE_W;

   // configuration
   logic [EdW-1:0] edition_ff;
   logic [EnW-1:0] enforce_ff;

   // input register
   logic            s1_vld_ff, s1_vld_in;
   logic [ClsW-1:0] cls_ff;
   logic [ArgW-1:0] arg_ff;
   logic            req_acc, adv;

   // modifier state
   logic [WcW-1:0]  width_ff, width_in;
   logic [ScW-1:0]  scale_ff, scale_in;
   logic [ArgW-1:0] refop_ff, refop_in;
   logic [ArgW-1:0] refinc_ff, refinc_in;
   logic [ArgW-1:0] localw_ff, localw_in;
   logic [FwW-1:0]  floatw_ff, floatw_in;
   logic [ArgW-1:0] textw_ff, textw_in;
   logic [FlW-1:0]  flag_ff, flag_in;

   // per item results
   logic [StW-1:0]  st;
   logic [SwW-1:0]  strw;
   logic            clr;

   // operator 7 width: (10y + 2) / 3 by reciprocal
   logic [11:0]     incr_num;
   logic [23:0]     incr_prod;
   logic [WcW-1:0]  incr_width;

   // stack
   bost_pkg::stk_cmd_type stk_cmd;
   logic                  stk_full;
   logic [SumW-1:0]       stk_sum;
   logic [AtW-1:0]        assoc_tot;

   // result register
   logic            rsp_vld_ff, rsp_vld_in;
   logic [91:0]     rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         edition_ff <= bost_pkg::ED_4;
         enforce_ff <= bost_pkg::ENF_WARN;
      end else if (csr_valid) begin
         case (csr_index)
            bost_pkg::CSR_EDITION: edition_ff <= csr_data;
            bost_pkg::CSR_ENFORCE: enforce_ff <= csr_data[EnW-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign adv        = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || adv;
   assign req_acc    = req_tvalid && req_tready;
   assign s1_vld_in  = req_acc || (s1_vld_ff && !adv);
   assign rsp_vld_in = adv || (rsp_vld_ff && !rsp_tready);

   assign incr_num   = {1'b0, arg_ff, 3'b000} + {3'b000, arg_ff, 1'b0} + 12'd2;
   assign incr_prod  = incr_num * bost_pkg::RECIP3;
   assign incr_width = incr_prod[bost_pkg::RECIP3_SHR +: WcW];

   always_comb begin
      width_in  = width_ff;
      scale_in  = scale_ff;
      refop_in  = refop_ff;
      refinc_in = refinc_ff;
      localw_in = localw_ff;
      floatw_in = floatw_ff;
      textw_in  = textw_ff;
      flag_in   = flag_ff;
      st        = bost_pkg::ST_OK;
      strw      = '0;
      clr       = 1'b0;
      stk_cmd   = '{push: 1'b0, pop: 1'b0, data: arg_ff};
      case (cls_ff)
         bost_pkg::OPC_WIDTH: begin
            width_in = (arg_ff == '0) ? '0
                       : WcW'(arg_ff) - WcW'(bost_pkg::ARG_BIAS);
         end
         bost_pkg::OPC_SCALE: begin
            scale_in = (arg_ff == '0) ? '0
                       : ScW'(arg_ff) - ScW'(bost_pkg::ARG_BIAS);
         end
         bost_pkg::OPC_REFVAL: begin
            refop_in = (arg_ff == bost_pkg::ARG_MAX) ? '0 : arg_ff;
            clr      = (arg_ff == '0);
         end
         bost_pkg::OPC_ASSOC: begin
            stk_cmd.push = adv && (arg_ff != '0);
            stk_cmd.pop  = adv && (arg_ff == '0);
            if (arg_ff != '0 && stk_full) begin
               st = bost_pkg::ST_OVERFLOW;
            end
         end
         bost_pkg::OPC_STRING: begin
            strw = {arg_ff, 3'b000};
         end
         bost_pkg::OPC_LOCAL: begin
            localw_in = arg_ff;
         end
         bost_pkg::OPC_INCR: begin
            if (arg_ff == '0) begin
               width_in  = '0;
               scale_in  = '0;
               refinc_in = '0;
            end else begin
               width_in  = incr_width;
               scale_in  = ScW'(arg_ff);
               refinc_in = arg_ff;
            end
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_4, st);
         end
         bost_pkg::OPC_TEXT: begin
            textw_in = arg_ff;
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_4, st);
         end
         bost_pkg::OPC_FLOAT: begin
            if (arg_ff == '0 || arg_ff == bost_pkg::ARG_FL32
                || arg_ff == bost_pkg::ARG_FL64) begin
               floatw_in = FwW'(arg_ff);
            end else begin
               st = bost_pkg::ST_FLOAT_BAD;
            end
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_5, st);
         end
         bost_pkg::OPC_QUAL: begin
            if (arg_ff == '0) begin
               flag_in[bost_pkg::FL_QUAL] = 1'b1;
            end
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_3, st);
         end
         bost_pkg::OPC_SUBST: begin
            if (arg_ff == '0) begin
               flag_in[bost_pkg::FL_SUBST] = 1'b1;
            end
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_3, st);
         end
         bost_pkg::OPC_STATS: begin
            if (arg_ff == '0) begin
               flag_in[bost_pkg::FL_STATS] = 1'b1;
            end
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_3, st);
         end
         bost_pkg::OPC_BMAP: begin
            flag_in[bost_pkg::FL_BMAP] = 1'b1;
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_3, st);
         end
         bost_pkg::OPC_REUSE: begin
            flag_in[bost_pkg::FL_REUSE] = 1'b1;
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_3, st);
         end
         bost_pkg::OPC_EVENT: begin
            flag_in[bost_pkg::FL_EVENT] = (arg_ff != bost_pkg::ARG_MAX);
            st = bost_pkg::edition_check(edition_ff, enforce_ff, bost_pkg::ED_4, st);
         end
         default: begin
            st = bost_pkg::ST_UNSUPP;
         end
      endcase
   end

   bost_stack #(
      .DEPTH (ASSOC_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stk_cmd),
      .full    (stk_full),
      .sum_nxt (stk_sum)
   );

   // sum only exceeds the field for deep stacks
   assign assoc_tot = ({{(32 - SumW){1'b0}}, stk_sum} > 32'd4095) ? {AtW{1'b1}}
                      : AtW'(stk_sum);

   assign rsp_data_in = {clr, strw, assoc_tot, flag_in, textw_in, floatw_in,
                         localw_in, refinc_in, refop_in, scale_in, width_in, st};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         width_ff   <= '0;
         scale_ff   <= '0;
         refop_ff   <= '0;
         refinc_ff  <= '0;
         localw_ff  <= '0;
         floatw_ff  <= '0;
         textw_ff   <= '0;
         flag_ff    <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            width_ff  <= width_in;
            scale_ff  <= scale_in;
            refop_ff  <= refop_in;
            refinc_ff <= refinc_in;
            localw_ff <= localw_in;
            floatw_ff <= floatw_in;
            textw_ff  <= textw_in;
            flag_ff   <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cls_ff <= req_tdata[ClsW-1:0];
         arg_ff <= req_tdata[ClsW +: ArgW];
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   a_float_legal: assert property (@(posedge clock) disable iff (reset)
      floatw_ff == '0 || floatw_ff == FwW'(32) || floatw_ff == FwW'(64))
      else $error("float width register holds an illegal width");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      adv |-> st <= bost_pkg::ST_OVERFLOW)
      else $error("status code out of range");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_vld_ff && !rsp_tready |-> !req_tready)
      else $error("item taken while both stages are held");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(adv) && !$past(reset) |-> $stable(flag_ff) && $stable(width_ff))
      else $error("modifier state changed without an item");

endmodule

// ----- sim/operator_snapshot_checker.sv -----
// Checker for the operator state tracker: predicts each snapshot and compares it with the block.
module operator_snapshot_checker
   import bost_pkg::*;
#(
   parameter int ASSOC_DEPTH = ASSOC_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // op_class[5:0], op_arg[13:6], zero pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,    // status .. clear_overrides, from bit 0 up
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data,
   output int          fail_count,
   output int          snapshots_due
);

   localparam logic [ENFORCE_W-1:0] ENFORCE_RST = ENF_WARN;

   // Same bit order as rsp_tdata: status sits in the lowest bits
   typedef struct packed {
      logic                   clear_overrides;
      logic [STRING_W_W-1:0]  string_width;
      logic [ASSOC_TOT_W-1:0] assoc_total_bits;
      logic [FLAGS_W-1:0]     mode_flags;
      logic [7:0]             text_redefine;
      logic [FLOAT_W_W-1:0]   float_width;
      logic [7:0]             local_width;
      logic [7:0]             ref_value_increase;
      logic [7:0]             ref_value_op;
      logic [SCALE_CHG_W-1:0] scale_change;
      logic [WIDTH_CHG_W-1:0] width_change;
      logic [STATUS_W-1:0]    status;
   } snapshot_type;

   logic [EDITION_W-1:0]   ed_q;
   logic [ENFORCE_W-1:0]   enf_q;
   logic [WIDTH_CHG_W-1:0] width_q;
   logic [SCALE_CHG_W-1:0] scale_q;
   logic [7:0]             refop_q;
   logic [7:0]             refinc_q;
   logic [7:0]             localw_q;
   logic [FLOAT_W_W-1:0]   floatw_q;
   logic [7:0]             textw_q;
   logic [FLAGS_W-1:0]     flags_q;
   logic [7:0]             assoc_mem [ASSOC_DEPTH];
   int                     assoc_cnt;
   int                     assoc_acc;

   snapshot_type snapshot_q [$];
   snapshot_type got_snap;
   snapshot_type want_snap;

   function automatic logic [STATUS_W-1:0] gate_by_edition(
      input logic [EDITION_W-1:0] intro,
      input logic [STATUS_W-1:0]  st
   );
      logic [STATUS_W-1:0] res;
      if (ed_q >= intro || enf_q == ENF_LAX) begin
         res = st;
      end else if (enf_q == ENF_STRICT) begin
         res = ST_ED_REJECT;
      end else begin
         res = ST_ED_WARN;   // level 3 behaves as warn
      end
      return res;
   endfunction

   // Applies one operator to the modifier copy and returns the snapshot after it
   task automatic apply_operator(
      input  logic [OP_CLASS_W-1:0] x,
      input  logic [OP_ARG_W-1:0]   y,
      output snapshot_type          s
   );
      logic [STATUS_W-1:0]   st;
      logic [STRING_W_W-1:0] strw;
      logic                  clr;
      st   = ST_OK;
      strw = '0;
      clr  = 1'b0;
      case (x)
         OPC_WIDTH: width_q = (y == '0) ? '0 : WIDTH_CHG_W'(y) - WIDTH_CHG_W'(ARG_BIAS);
         OPC_SCALE: scale_q = (y == '0) ? '0 : SCALE_CHG_W'(y) - SCALE_CHG_W'(ARG_BIAS);
         OPC_REFVAL: begin
            if (y == ARG_MAX) begin
               refop_q = '0;
            end else begin
               refop_q = y;
               clr     = (y == '0);
            end
         end
         OPC_ASSOC: begin
            if (y != '0) begin
               if (assoc_cnt < ASSOC_DEPTH) begin
                  assoc_mem[assoc_cnt] = y;
                  assoc_cnt++;
                  assoc_acc += int'(y);
               end else begin
                  st = ST_OVERFLOW;
               end
            end else if (assoc_cnt > 0) begin
               assoc_cnt--;
               assoc_acc -= int'(assoc_mem[assoc_cnt]);
            end
         end
         OPC_STRING: strw = {y, 3'b000};
         OPC_LOCAL:  localw_q = y;
         OPC_INCR: begin
            if (y == '0) begin
               width_q  = '0;
               scale_q  = '0;
               refinc_q = '0;
            end else begin
               width_q  = WIDTH_CHG_W'((10 * int'(y) + 2) / 3);
               scale_q  = SCALE_CHG_W'(y);
               refinc_q = y;
            end
            st = gate_by_edition(ED_4, st);
         end
         OPC_TEXT: begin
            textw_q = y;
            st = gate_by_edition(ED_4, st);
         end
         OPC_FLOAT: begin
            if (y == ARG_FL32 || y == ARG_FL64 || y == '0) floatw_q = FLOAT_W_W'(y);
            else st = ST_FLOAT_BAD;
            st = gate_by_edition(ED_5, st);
         end
         OPC_QUAL: begin
            if (y == '0) flags_q[FL_QUAL] = 1'b1;
            st = gate_by_edition(ED_3, st);
         end
         OPC_SUBST: begin
            if (y == '0) flags_q[FL_SUBST] = 1'b1;
            st = gate_by_edition(ED_3, st);
         end
         OPC_STATS: begin
            if (y == '0) flags_q[FL_STATS] = 1'b1;
            st = gate_by_edition(ED_3, st);
         end
         OPC_BMAP: begin
            flags_q[FL_BMAP] = 1'b1;
            st = gate_by_edition(ED_3, st);
         end
         OPC_REUSE: begin
            flags_q[FL_REUSE] = 1'b1;
            st = gate_by_edition(ED_3, st);
         end
         OPC_EVENT: begin
            flags_q[FL_EVENT] = (y != ARG_MAX);
            st = gate_by_edition(ED_4, st);
         end
         default: st = ST_UNSUPP;
      endcase
      s.status             = st;
      s.width_change       = width_q;
      s.scale_change       = scale_q;
      s.ref_value_op       = refop_q;
      s.ref_value_increase = refinc_q;
      s.local_width        = localw_q;
      s.float_width        = floatw_q;
      s.text_redefine      = textw_q;
      s.mode_flags         = flags_q;
      s.assoc_total_bits   = (assoc_acc > 4095) ? '1 : ASSOC_TOT_W'(assoc_acc);
      s.string_width       = strw;
      s.clear_overrides    = clr;
   endtask

   task automatic check_field(input string fname, input int unsigned want,
                              input logic [11:0] got);
      if (got !== 12'(want)) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         ed_q      = ED_4;
         enf_q     = ENFORCE_RST;
         width_q   = '0;
         scale_q   = '0;
         refop_q   = '0;
         refinc_q  = '0;
         localw_q  = '0;
         floatw_q  = '0;
         textw_q   = '0;
         flags_q   = '0;
         assoc_cnt = 0;
         assoc_acc = 0;
         snapshot_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_EDITION) ed_q = csr_data[EDITION_W-1:0];
            else enf_q = csr_data[ENFORCE_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            apply_operator(req_tdata[5:0], req_tdata[13:6], want_snap);
            snapshot_q.push_back(want_snap);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_snap = snapshot_type'(rsp_tdata[91:0]);
            if (snapshot_q.size() == 0) begin
               $display("%0t unexpected item: expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want_snap = snapshot_q.pop_front();
               check_field("status", want_snap.status, got_snap.status);
               check_field("width_change", want_snap.width_change, got_snap.width_change);
               check_field("scale_change", want_snap.scale_change, got_snap.scale_change);
               check_field("ref_value_op", want_snap.ref_value_op, got_snap.ref_value_op);
               check_field("ref_value_increase", want_snap.ref_value_increase,
                           got_snap.ref_value_increase);
               check_field("local_width", want_snap.local_width, got_snap.local_width);
               check_field("float_width", want_snap.float_width, got_snap.float_width);
               check_field("text_redefine", want_snap.text_redefine, got_snap.text_redefine);
               check_field("mode_flags", want_snap.mode_flags, got_snap.mode_flags);
               check_field("assoc_total_bits", want_snap.assoc_total_bits,
                           got_snap.assoc_total_bits);
               check_field("string_width", want_snap.string_width, got_snap.string_width);
               check_field("clear_overrides", want_snap.clear_overrides,
                           got_snap.clear_overrides);
            end
         end
      end
      snapshots_due = snapshot_q.size();
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the operator state tracker: clock, reset, stimulus and verdict.
module tb;
   import bost_pkg::*;

   localparam logic [ENFORCE_W-1:0] ENF_WARN     = 2'd1;
   localparam logic [ENFORCE_W-1:0] ENF_WARN_ALT = 2'd3;   // undefined level, acts as warn
   localparam int NUM_PHASES = 8;
   localparam int PHASE_LEN  = 235;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [3:0]  csr_data   = '0;

   int fail_count;
   int snapshots_due;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   always #4 clock = ~clock;

   bufr_operator_state_tracker_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   operator_snapshot_checker snapshot_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .snapshots_due (snapshots_due)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one operator item; returns at the edge where it was taken
   task automatic send_op(input logic [OP_CLASS_W-1:0] x, input logic [OP_ARG_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds the sender off until every snapshot has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (snapshots_due != 0);
      @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [3:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [OP_CLASS_W-1:0] pick_class();
      logic [OP_CLASS_W-1:0] c;
      case ($urandom_range(14))
         0:       c = OPC_WIDTH;
         1:       c = OPC_SCALE;
         2:       c = OPC_REFVAL;
         3:       c = OPC_ASSOC;
         4:       c = OPC_STRING;
         5:       c = OPC_LOCAL;
         6:       c = OPC_INCR;
         7:       c = OPC_TEXT;
         8:       c = OPC_FLOAT;
         9:       c = OPC_QUAL;
         10:      c = OPC_SUBST;
         11:      c = OPC_STATS;
         12:      c = OPC_BMAP;
         13:      c = OPC_REUSE;
         default: c = OPC_EVENT;
      endcase
      return c;
   endfunction

   // Operands lean towards the values with a meaning of their own
   function automatic logic [OP_ARG_W-1:0] pick_arg();
      logic [OP_ARG_W-1:0] a;
      case ($urandom_range(11))
         0:       a = '0;
         1:       a = ARG_MAX;
         2:       a = ARG_BIAS;
         3:       a = ARG_FL32;
         4:       a = ARG_FL64;
         5:       a = 8'd1;
         default: a = OP_ARG_W'($urandom_range(255));
      endcase
      return a;
   endfunction

   initial begin
      int sent;
      int n;
      int r;
      bit paused;
      logic [EDITION_W-1:0] ed_set [NUM_PHASES];
      logic [ENFORCE_W-1:0] enf_set [NUM_PHASES];

      ed_set  = '{4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd4, 4'd1, 4'd0};
      enf_set = '{ENF_LAX, ENF_STRICT, ENF_WARN, ENF_WARN_ALT,
                  ENF_STRICT, ENF_WARN, ENF_STRICT, ENF_WARN};
      ed_set[NUM_PHASES-1] = EDITION_W'($urandom_range(15));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset settings: edition 4, warn only
      send_op(OPC_WIDTH, 8'd0);
      send_op(OPC_WIDTH, ARG_MAX);
      send_op(OPC_SCALE, 8'd0);
      send_op(OPC_SCALE, ARG_MAX);
      send_op(OPC_REFVAL, 8'd0);
      send_op(OPC_REFVAL, ARG_MAX);
      send_op(OPC_REFVAL, 8'd127);
      send_op(OPC_ASSOC, ARG_MAX);
      send_op(OPC_ASSOC, 8'd0);
      send_op(OPC_ASSOC, 8'd0);       // pop with nothing on the stack
      send_op(OPC_STRING, ARG_MAX);
      send_op(OPC_LOCAL, ARG_MAX);
      send_op(OPC_INCR, ARG_MAX);
      send_op(OPC_INCR, 8'd0);
      send_op(OPC_TEXT, ARG_MAX);
      send_op(OPC_FLOAT, ARG_FL64);   // newer than edition 4
      send_op(OPC_FLOAT, 8'd17);      // bad width and edition warning together
      send_op(OPC_QUAL, 8'd0);
      send_op(OPC_SUBST, 8'd0);
      send_op(OPC_STATS, 8'd0);
      send_op(OPC_BMAP, 8'd3);
      send_op(OPC_REUSE, 8'd9);
      send_op(OPC_EVENT, 8'd0);
      send_op(OPC_EVENT, ARG_MAX);
      send_op(6'd21, 8'd0);           // known but unimplemented class
      send_op(6'd63, ARG_MAX);
      drain_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         write_register(CSR_EDITION, ed_set[p]);
         // upper data bits are don't-care for the enforcement level
         write_register(CSR_ENFORCE, {2'($urandom_range(3)), enf_set[p]});
         sent   = 0;
         paused = 1'b0;
         while (sent < PHASE_LEN) begin
            r = $urandom_range(99);
            if (r < 4) begin
               // fill the stack past its depth so the overflow case shows up
               n = $urandom_range(17, 20);
               repeat (n) send_op(OPC_ASSOC, OP_ARG_W'($urandom_range(1, 255)));
               sent += n;
            end else if (r < 14) begin
               n = $urandom_range(1, 6);
               repeat (n) send_op(OPC_ASSOC, 8'd0);
               sent += n;
            end else if (r < 26) begin
               send_op(OP_CLASS_W'($urandom_range(63)), OP_ARG_W'($urandom_range(255)));
               sent++;
            end else begin
               send_op(pick_class(), pick_arg());
               sent++;
            end
            if (!paused && sent >= PHASE_LEN / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
         drain_results();
      end

      repeat (16) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && snapshots_due == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
